### hw/rtl/tml_pkg.sv
// ----------------------------------------------------------------------------
// tml_pkg: shared types and constants for the tube motion likelihood block
// Fixed-point widths, register codes and the sideband structs that ride
// along the divider pipelines.
// ----------------------------------------------------------------------------
package tml_pkg;

  localparam int unsigned FRAC_W   = 12;           // Q4.12 / Q0.12 fraction
  localparam int unsigned ONE_Q12  = 4096;         // 1.0
  localparam int unsigned DIR_W    = 14;
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LIK_W    = 13;

  // first divider bank: base ratio, speed ramp, left and right bound
  localparam int unsigned D1_LANES = 4;
  localparam int unsigned D1_NW    = 29;
  localparam int unsigned D1_DW    = 17;
  localparam int unsigned D1_QW    = 17;
  // second divider bank: left and right lateral ramps
  localparam int unsigned D2_LANES = 2;
  localparam int unsigned D2_NW    = 27;
  localparam int unsigned D2_DW    = 15;
  localparam int unsigned D2_QW    = 12;

  // bound over horizon is clamped to +/- this; beyond it no ramp can trigger
  localparam int unsigned BND_SAT  = 131072;
  localparam int unsigned BND_W    = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZON      = 2'd0,
    REG_SIDE_MARGIN  = 2'd1,
    REG_MIN_SPEED    = 2'd2,
    REG_SPEED_MARGIN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VEL_W-1:0] vl;
    logic                    neg_l;
    logic                    neg_r;
    logic                    ovf_l;
    logic                    ovf_r;
    logic                    pzero;
    logic                    pramp;
  } prep_tag_t;

  typedef struct packed {
    logic [LIK_W-1:0] l0;
    logic [LIK_W-1:0] fp;
    logic             zero;
    logic             lr;
    logic             rr;
  } fac_tag_t;

  // sum of products / 4096, truncated toward zero, saturated to Q4.12
  function automatic logic signed [VEL_W-1:0] sat_q12(input logic signed [30:0] s);
    logic signed [18:0] q;
    q = s[30:12];
    if (s[30] && (s[11:0] != 12'd0)) q = q + 19'sd1;
    if (q > 19'sd32767) return 16'sh7fff;
    else if (q < -19'sd32768) return 16'sh8000;
    else return q[15:0];
  endfunction

endpackage

### hw/rtl/tml_div.sv
// ----------------------------------------------------------------------------
// tml_div: pipelined restoring divider bank
// One quotient bit per stage for LANES independent lanes. The caller
// guarantees num < den * 2**QW so the quotient fits QW bits.
// ----------------------------------------------------------------------------
module tml_div #(
  parameter int unsigned LANES = 2,
  parameter int unsigned NW    = 27,
  parameter int unsigned DW    = 15,
  parameter int unsigned QW    = 12,
  parameter int unsigned TW    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][NW-1:0]     num_i,
  input  logic [LANES-1:0][DW-1:0]     den_i,
  input  logic [TW-1:0]                tag_i,
  output logic                         valid_o,
  output logic [LANES-1:0][QW-1:0]     quo_o,
  output logic [TW-1:0]                tag_o
);

  logic [QW-1:0]                   v_q;
  logic [QW-1:0][LANES-1:0][DW-1:0] rem_q, rem_d;
  logic [QW-1:0][LANES-1:0][DW-1:0] den_q;
  logic [QW-1:0][LANES-1:0][QW-1:0] lo_q, lo_d;
  logic [QW-1:0][LANES-1:0][QW-1:0] quo_q, quo_d;
  logic [QW-1:0][TW-1:0]            tag_q;

  always_comb begin
    logic [DW-1:0] src_rem;
    logic [DW-1:0] src_den;
    logic [QW-1:0] src_lo;
    logic [QW-1:0] src_quo;
    logic [DW:0]   trial;
    logic          ge;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          src_rem = DW'(num_i[l][NW-1:QW]);
          src_den = den_i[l];
          src_lo  = num_i[l][QW-1:0];
          src_quo = '0;
        end else begin
          src_rem = rem_q[s-1][l];
          src_den = den_q[s-1][l];
          src_lo  = lo_q[s-1][l];
          src_quo = quo_q[s-1][l];
        end
        trial = {src_rem, src_lo[QW-1]};
        ge    = trial >= {1'b0, src_den};
        rem_d[s][l] = ge ? DW'(trial - {1'b0, src_den}) : trial[DW-1:0];
        lo_d[s][l]  = src_lo << 1;
        quo_d[s][l] = {src_quo[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
      quo_q <= quo_d;
      den_q <= {den_q[QW-2:0], den_i};
      tag_q <= {tag_q[QW-2:0], tag_i};
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

### hw/rtl/tml_rot.sv
// ----------------------------------------------------------------------------
// tml_rot: velocity rotation into the tube frame
// Stage 1 forms the four products, stage 2 sums, truncates and saturates.
// ----------------------------------------------------------------------------
module tml_rot (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [tml_pkg::DIR_W-1:0]    dir_x_i,
  input  logic signed [tml_pkg::DIR_W-1:0]    dir_y_i,
  input  logic signed [tml_pkg::VEL_W-1:0]    vel_x_i,
  input  logic signed [tml_pkg::VEL_W-1:0]    vel_y_i,
  input  logic signed [tml_pkg::VEL_W-1:0]    bl_i,
  input  logic signed [tml_pkg::VEL_W-1:0]    br_i,
  output logic                                valid_o,
  output logic signed [tml_pkg::VEL_W-1:0]    vt_o,
  output logic signed [tml_pkg::VEL_W-1:0]    vl_o,
  output logic signed [tml_pkg::VEL_W-1:0]    bl_o,
  output logic signed [tml_pkg::VEL_W-1:0]    br_o
);

  logic                             v1_q, v2_q;
  logic signed [29:0]               pxx_q, pyy_q, pyx_q, pxy_q;
  logic signed [tml_pkg::VEL_W-1:0] bl1_q, br1_q;
  logic signed [tml_pkg::VEL_W-1:0] vt_q, vl_q, bl2_q, br2_q;
  logic signed [30:0]               st_d, sl_d;

  assign st_d = 31'(pxx_q) + 31'(pyy_q);
  assign sl_d = 31'(pyx_q) - 31'(pxy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxx_q <= 30'(vel_x_i) * 30'(dir_x_i);
      pyy_q <= 30'(vel_y_i) * 30'(dir_y_i);
      pyx_q <= 30'(vel_y_i) * 30'(dir_x_i);
      pxy_q <= 30'(vel_x_i) * 30'(dir_y_i);
      bl1_q <= bl_i;
      br1_q <= br_i;
      vt_q  <= tml_pkg::sat_q12(st_d);
      vl_q  <= tml_pkg::sat_q12(sl_d);
      bl2_q <= bl1_q;
      br2_q <= br1_q;
    end
  end

  assign valid_o = v2_q;
  assign vt_o    = vt_q;
  assign vl_o    = vl_q;
  assign bl_o    = bl2_q;
  assign br_o    = br2_q;

endmodule

### hw/rtl/tml_scale.sv
// ----------------------------------------------------------------------------
// tml_scale: applies the three ramp factors in turn
// One Q0.12 multiply per stage with truncation, zero forced at the end.
// ----------------------------------------------------------------------------
module tml_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         zero_i,
  input  logic [tml_pkg::LIK_W-1:0]    l_i,
  input  logic [tml_pkg::LIK_W-1:0]    f0_i,
  input  logic [tml_pkg::LIK_W-1:0]    f1_i,
  input  logic [tml_pkg::LIK_W-1:0]    f2_i,
  output logic                         valid_o,
  output logic [tml_pkg::LIK_W-1:0]    l_o
);

  localparam int unsigned PW = 2 * tml_pkg::LIK_W;

  logic [2:0]                   v_q;
  logic [1:0]                   z_q;
  logic [tml_pkg::LIK_W-1:0]    l1_q, l2_q, l3_q;
  logic [tml_pkg::LIK_W-1:0]    f1_q, f2_q, f2b_q;
  logic [PW-1:0]                p1, p2, p3;

  // factors are at most 1.0, so each product shifted down fits LIK_W
  assign p1 = PW'(l_i) * PW'(f0_i);
  assign p2 = PW'(l1_q) * PW'(f1_q);
  assign p3 = PW'(l2_q) * PW'(f2b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q   <= {z_q[0], zero_i};
      l1_q  <= p1[tml_pkg::FRAC_W +: tml_pkg::LIK_W];
      f1_q  <= f1_i;
      f2_q  <= f2_i;
      l2_q  <= p2[tml_pkg::FRAC_W +: tml_pkg::LIK_W];
      f2b_q <= f2_q;
      l3_q  <= z_q[1] ? '0 : p3[tml_pkg::FRAC_W +: tml_pkg::LIK_W];
    end
  end

  assign valid_o = v_q[2];
  assign l_o     = l3_q;

endmodule

### hw/rtl/tube_motion_likelihood.sv
// ----------------------------------------------------------------------------
// tube_motion_likelihood: likelihood that a motion follows a tube
// Rotates the velocity into the tube frame, forms the along/total speed
// ratio and scales it by the forward-progress and lateral-bound ramps.
// ----------------------------------------------------------------------------
// Takes one item every clock while stall_o is low and returns one result
// per item, in order. Between input and output lie the two bit-serial
// divider pipelines (17 stages for the speed ratio and bound/horizon
// quotients, 12 for the lateral ramp factors) plus rotation, preparation,
// bound and three ramp-multiply stages and the output register. The whole
// pipeline advances together; a skid register at the output takes one more
// result after the output stalls, after which stall_o rises until the
// held output is taken. Registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i and must only change while no item is in flight. A horizon
// of zero divides as one; zero margins make the matching ramp a hard step.
module tube_motion_likelihood (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input item channel
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [tml_pkg::DIR_W-1:0]     dir_x_i,
  input  logic signed [tml_pkg::DIR_W-1:0]     dir_y_i,
  input  logic signed [tml_pkg::VEL_W-1:0]     vel_x_i,
  input  logic signed [tml_pkg::VEL_W-1:0]     vel_y_i,
  input  logic signed [tml_pkg::VEL_W-1:0]     bound_left_i,
  input  logic signed [tml_pkg::VEL_W-1:0]     bound_right_i,
  // register write port
  input  logic                                 cfg_we_i,
  input  logic [tml_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tml_pkg::CFG_W-1:0]            cfg_data_i,
  // result channel
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [tml_pkg::LIK_W-1:0]            likelihood_o
);

  localparam int unsigned CW = tml_pkg::CFG_W;
  localparam int unsigned LW = tml_pkg::LIK_W;
  localparam int unsigned VW = tml_pkg::VEL_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0] hz_q, lm_q, ms_q, sm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz_q <= CW'(4096);
      lm_q <= CW'(2048);
      ms_q <= CW'(410);
      sm_q <= CW'(2048);
    end else if (cfg_we_i) begin
      unique case (tml_pkg::cfg_reg_e'(cfg_idx_i))
        tml_pkg::REG_HORIZON:      hz_q <= cfg_data_i;
        tml_pkg::REG_SIDE_MARGIN:  lm_q <= cfg_data_i;
        tml_pkg::REG_MIN_SPEED:    ms_q <= cfg_data_i;
        tml_pkg::REG_SPEED_MARGIN: sm_q <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: one global advance, held only while the skid is full
  // ---------------------------------------------------------------------------
  logic out_v_q, skid_v_q;
  logic en;

  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  // ---------------------------------------------------------------------------
  // rotation (2 stages)
  // ---------------------------------------------------------------------------
  logic                 r_v;
  logic signed [VW-1:0] r_vt, r_vl, r_bl, r_br;

  tml_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .vel_x_i (vel_x_i),
    .vel_y_i (vel_y_i),
    .bl_i    (bound_left_i),
    .br_i    (bound_right_i),
    .valid_o (r_v),
    .vt_o    (r_vt),
    .vl_o    (r_vl),
    .bl_o    (r_bl),
    .br_o    (r_br)
  );

  // ---------------------------------------------------------------------------
  // preparation: divider operands and ramp decisions on the forward speed
  // ---------------------------------------------------------------------------
  logic [16:0]             abs_vl, mag_l, mag_r;
  logic [16:0]             den_base;
  logic                    vt_pos, ge_ms, lt_end;
  logic [CW-1:0]           hz_eff, vt_diff;
  logic                    ovf_l, ovf_r;
  tml_pkg::prep_tag_t      prep_tag_d;
  logic [tml_pkg::D1_LANES-1:0][tml_pkg::D1_NW-1:0] d1_num_d;
  logic [tml_pkg::D1_LANES-1:0][tml_pkg::D1_DW-1:0] d1_den_d;

  assign abs_vl   = r_vl[VW-1] ? 17'(-{r_vl[VW-1], r_vl}) : {1'b0, r_vl};
  assign mag_l    = r_bl[VW-1] ? 17'(-{r_bl[VW-1], r_bl}) : {1'b0, r_bl};
  assign mag_r    = r_br[VW-1] ? 17'(-{r_br[VW-1], r_br}) : {1'b0, r_br};
  assign vt_pos   = !r_vt[VW-1] && (r_vt != '0);
  assign den_base = {2'b00, r_vt[14:0]} + abs_vl;
  // a negative forward speed is always below the minimum
  assign ge_ms    = !r_vt[VW-1] && (r_vt[14:0] >= ms_q);
  assign lt_end   = r_vt[VW-1] || ({1'b0, r_vt[14:0]} < ({1'b0, ms_q} + {1'b0, sm_q}));
  assign vt_diff  = r_vt[14:0] - ms_q;
  assign hz_eff   = (hz_q == '0) ? CW'(1) : hz_q;
  // |bound| * 4096 / horizon reaches the clamp when |bound| >= 32 * horizon
  assign ovf_l    = {3'b000, mag_l} >= {hz_eff, 5'b00000};
  assign ovf_r    = {3'b000, mag_r} >= {hz_eff, 5'b00000};

  always_comb begin
    prep_tag_d.vl    = r_vl;
    prep_tag_d.neg_l = r_bl[VW-1];
    prep_tag_d.neg_r = r_br[VW-1];
    prep_tag_d.ovf_l = ovf_l;
    prep_tag_d.ovf_r = ovf_r;
    prep_tag_d.pzero = !ge_ms;
    prep_tag_d.pramp = ge_ms && lt_end;

    // base ratio; zero or negative forward speed gives zero
    d1_num_d[0] = vt_pos ? tml_pkg::D1_NW'({r_vt[14:0], 12'd0}) : '0;
    d1_den_d[0] = vt_pos ? den_base : tml_pkg::D1_DW'(1);
    // forward-progress ramp factor
    d1_num_d[1] = prep_tag_d.pramp ? tml_pkg::D1_NW'({vt_diff, 12'd0}) : '0;
    d1_den_d[1] = prep_tag_d.pramp ? tml_pkg::D1_DW'(sm_q) : tml_pkg::D1_DW'(1);
    // bound magnitudes over the horizon
    d1_num_d[2] = ovf_l ? '0 : tml_pkg::D1_NW'({mag_l, 12'd0});
    d1_den_d[2] = ovf_l ? tml_pkg::D1_DW'(1) : tml_pkg::D1_DW'(hz_eff);
    d1_num_d[3] = ovf_r ? '0 : tml_pkg::D1_NW'({mag_r, 12'd0});
    d1_den_d[3] = ovf_r ? tml_pkg::D1_DW'(1) : tml_pkg::D1_DW'(hz_eff);
  end

  logic                p_v_q;
  tml_pkg::prep_tag_t  p_tag_q;
  logic [tml_pkg::D1_LANES-1:0][tml_pkg::D1_NW-1:0] p_num_q;
  logic [tml_pkg::D1_LANES-1:0][tml_pkg::D1_DW-1:0] p_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= r_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_tag_q <= prep_tag_d;
      p_num_q <= d1_num_d;
      p_den_q <= d1_den_d;
    end
  end

  // ---------------------------------------------------------------------------
  // first divider bank (17 stages)
  // ---------------------------------------------------------------------------
  logic                 d1_v;
  tml_pkg::prep_tag_t   d1_tag;
  logic [tml_pkg::D1_LANES-1:0][tml_pkg::D1_QW-1:0] d1_quo;

  tml_div #(
    .LANES (tml_pkg::D1_LANES),
    .NW    (tml_pkg::D1_NW),
    .DW    (tml_pkg::D1_DW),
    .QW    (tml_pkg::D1_QW),
    .TW    ($bits(tml_pkg::prep_tag_t))
  ) u_div_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .num_i   (p_num_q),
    .den_i   (p_den_q),
    .tag_i   (p_tag_q),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .tag_o   (d1_tag)
  );

  // ---------------------------------------------------------------------------
  // bound stage 1: signed, clamped bound-over-horizon values
  // ---------------------------------------------------------------------------
  logic [17:0]                      mag_tl, mag_tr;
  logic signed [tml_pkg::BND_W-1:0] tl_d, tr_d;

  assign mag_tl = d1_tag.ovf_l ? 18'(tml_pkg::BND_SAT) : {1'b0, d1_quo[2]};
  assign mag_tr = d1_tag.ovf_r ? 18'(tml_pkg::BND_SAT) : {1'b0, d1_quo[3]};
  assign tl_d   = d1_tag.neg_l ? -$signed({1'b0, mag_tl}) : $signed({1'b0, mag_tl});
  assign tr_d   = d1_tag.neg_r ? -$signed({1'b0, mag_tr}) : $signed({1'b0, mag_tr});

  logic                             b1_v_q;
  logic [LW-1:0]                    b1_l0_q, b1_fp_q;
  logic                             b1_pzero_q;
  logic signed [tml_pkg::BND_W-1:0] b1_tl_q, b1_tr_q;
  logic signed [VW-1:0]             b1_vl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_l0_q    <= d1_quo[0][LW-1:0];
      b1_fp_q    <= d1_tag.pramp ? LW'(d1_quo[1][11:0]) : LW'(tml_pkg::ONE_Q12);
      b1_pzero_q <= d1_tag.pzero;
      b1_tl_q    <= tl_d;
      b1_tr_q    <= tr_d;
      b1_vl_q    <= d1_tag.vl;
    end
  end

  // ---------------------------------------------------------------------------
  // bound stage 2: lateral ramp decisions and divider operands
  // ---------------------------------------------------------------------------
  logic signed [19:0] dl, dr;
  logic               lz, rz, lr, rr;
  tml_pkg::fac_tag_t  fac_tag_d;
  logic [tml_pkg::D2_LANES-1:0][tml_pkg::D2_NW-1:0] d2_num_d;
  logic [tml_pkg::D2_LANES-1:0][tml_pkg::D2_DW-1:0] d2_den_d;

  assign dl = $signed({{4{b1_vl_q[VW-1]}}, b1_vl_q}) - $signed({b1_tl_q[18], b1_tl_q});
  assign dr = $signed({b1_tr_q[18], b1_tr_q}) - $signed({{4{b1_vl_q[VW-1]}}, b1_vl_q});
  assign lz = dl[19];
  assign rz = dr[19];
  assign lr = !lz && (dl[18:0] < {4'd0, lm_q});
  assign rr = !rz && (dr[18:0] < {4'd0, lm_q});

  always_comb begin
    fac_tag_d.l0   = b1_l0_q;
    fac_tag_d.fp   = b1_fp_q;
    fac_tag_d.zero = b1_pzero_q || lz || rz;
    fac_tag_d.lr   = lr;
    fac_tag_d.rr   = rr;
    d2_num_d[0]    = lr ? {dl[14:0], 12'd0} : '0;
    d2_den_d[0]    = lr ? lm_q : tml_pkg::D2_DW'(1);
    d2_num_d[1]    = rr ? {dr[14:0], 12'd0} : '0;
    d2_den_d[1]    = rr ? lm_q : tml_pkg::D2_DW'(1);
  end

  logic               b2_v_q;
  tml_pkg::fac_tag_t  b2_tag_q;
  logic [tml_pkg::D2_LANES-1:0][tml_pkg::D2_NW-1:0] b2_num_q;
  logic [tml_pkg::D2_LANES-1:0][tml_pkg::D2_DW-1:0] b2_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_v_q <= 1'b0;
    end else if (en) begin
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_tag_q <= fac_tag_d;
      b2_num_q <= d2_num_d;
      b2_den_q <= d2_den_d;
    end
  end

  // ---------------------------------------------------------------------------
  // second divider bank (12 stages): lateral ramp factors
  // ---------------------------------------------------------------------------
  logic               d2_v;
  tml_pkg::fac_tag_t  d2_tag;
  logic [tml_pkg::D2_LANES-1:0][tml_pkg::D2_QW-1:0] d2_quo;

  tml_div #(
    .LANES (tml_pkg::D2_LANES),
    .NW    (tml_pkg::D2_NW),
    .DW    (tml_pkg::D2_DW),
    .QW    (tml_pkg::D2_QW),
    .TW    ($bits(tml_pkg::fac_tag_t))
  ) u_div_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b2_v_q),
    .num_i   (b2_num_q),
    .den_i   (b2_den_q),
    .tag_i   (b2_tag_q),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .tag_o   (d2_tag)
  );

  // ---------------------------------------------------------------------------
  // ramp scaling (3 stages)
  // ---------------------------------------------------------------------------
  logic [LW-1:0] fl, fr, s_l;
  logic          s_v;

  assign fl = d2_tag.lr ? LW'(d2_quo[0]) : LW'(tml_pkg::ONE_Q12);
  assign fr = d2_tag.rr ? LW'(d2_quo[1]) : LW'(tml_pkg::ONE_Q12);

  tml_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_v),
    .zero_i  (d2_tag.zero),
    .l_i     (d2_tag.l0),
    .f0_i    (d2_tag.fp),
    .f1_i    (fl),
    .f2_i    (fr),
    .valid_o (s_v),
    .l_o     (s_l)
  );

  // ---------------------------------------------------------------------------
  // output register with skid
  // ---------------------------------------------------------------------------
  logic [LW-1:0] out_q, skid_q;
  logic          take, push;

  assign take = out_v_q && !stall_i;
  assign push = en && s_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : s_l;
    end else if (push) begin
      skid_q <= s_l;
    end
  end

  assign valid_o      = out_v_q;
  assign likelihood_o = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && stall_i))
    else $error("skid filled without a stalled output");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (likelihood_o <= LW'(tml_pkg::ONE_Q12)))
    else $error("likelihood above 1.0");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> ($stable(p_tag_q) || !$past(skid_v_q)))
    else $error("pipeline advanced while the skid was full");

endmodule
